>>> rtl/link_uri_validator_macros.svh
// ----------------------------------------------------------------------------
// Link URI validator assertion macros
// Shared assertion forms for the checker of the link validator.
// ----------------------------------------------------------------------------
`ifndef LINK_URI_VALIDATOR_MACROS_SVH
`define LINK_URI_VALIDATOR_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define LUV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define LUV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/luv_pkg.sv
// ----------------------------------------------------------------------------
// Link URI validator package
// Types, codes and character tables shared by the validator modules.
// ----------------------------------------------------------------------------
package luv_pkg;

  localparam logic [7:0] BAR   = 8'h7C;
  localparam logic [7:0] SLASH = 8'h2F;
  localparam logic [4:0] HDR_DONE = 5'd31;
  localparam logic [4:0] PREFIX_LEN = 5'd8;
  localparam logic [5:0] HEX_SAT = 6'd33;
  localparam logic [5:0] HASH_LEN = 6'd32;

  localparam logic [3:0] VRD_NONE     = 4'd0;
  localparam logic [3:0] VRD_FILE_OK  = 4'd0;
  localparam logic [3:0] VRD_NOT_LINK = 4'd3;
  localparam logic [3:0] VRD_BAD_TYPE = 4'd4;
  localparam logic [3:0] VRD_FORMAT   = 4'd5;
  localparam logic [3:0] VRD_EMPTY    = 4'd6;
  localparam logic [3:0] VRD_BAD_NUM  = 4'd7;
  localparam logic [3:0] VRD_BAD_HASH = 4'd8;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_FILE   = 2'd1;
  localparam logic [1:0] KIND_SERVER = 2'd2;
  localparam logic [1:0] KIND_LIST   = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] link_kind;
    logic [3:0] verdict;
  } result_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = "e";
      3'd1: c = "d";
      3'd2: c = "2";
      3'd3: c = "k";
      3'd4: c = ":";
      3'd5: c = "/";
      3'd6: c = "/";
      default: c = "|";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] file_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = "f";
      2'd1: c = "i";
      2'd2: c = "l";
      default: c = "e";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] list_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = "s";
      4'd1: c = "e";
      4'd2: c = "r";
      4'd3: c = "v";
      4'd4: c = "e";
      4'd5: c = "r";
      4'd6: c = "l";
      4'd7: c = "i";
      4'd8: c = "s";
      4'd9: c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
  endfunction

endpackage

>>> rtl/luv_in_stage.sv
// ----------------------------------------------------------------------------
// Link URI validator input stage
// Registers one request from the input channel and holds it until it is used.
// ----------------------------------------------------------------------------
module luv_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  luv_pkg::item_t   in_item,
  input  logic             advance,
  output logic             stg_valid,
  output luv_pkg::item_t   stg_item
);

  logic           valid_r, valid_nxt;
  luv_pkg::item_t item_r;
  logic           take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;
  assign valid_nxt = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign stg_valid = valid_r;
  assign stg_item  = item_r;

endmodule

>>> rtl/luv_check.sv
// ----------------------------------------------------------------------------
// Link URI validator check logic
// Running match state for one link and the verdict on its final byte.
// ----------------------------------------------------------------------------
module luv_check (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  luv_pkg::item_t   item,
  output logic             res_valid,
  output luv_pkg::result_t res
);

  logic [4:0] mp_r, mp_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [1:0] fidx_r, fidx_nxt;
  logic       nonempty_r, nonempty_nxt;
  logic       digits_r, digits_nxt;
  logic [5:0] hcnt_r, hcnt_nxt;
  logic       hexok_r, hexok_nxt;
  logic [3:0] ferr_r, ferr_nxt;
  logic       await_r, await_nxt;

  always_comb begin
    logic [7:0] b;
    logic [3:0] ti;
    logic [1:0] last_field;
    logic       closed;
    logic       clr;
    b          = item.text_byte;
    ti         = 4'(mp_r - luv_pkg::PREFIX_LEN);
    last_field = (kind_r == luv_pkg::KIND_FILE) ? 2'd2 :
                 (kind_r == luv_pkg::KIND_SERVER) ? 2'd1 : 2'd0;
    clr        = 1'b0;
    closed     = 1'b0;

    mp_nxt       = mp_r;
    kind_nxt     = kind_r;
    fidx_nxt     = fidx_r;
    nonempty_nxt = nonempty_r;
    digits_nxt   = digits_r;
    hcnt_nxt     = hcnt_r;
    hexok_nxt    = hexok_r;
    ferr_nxt     = ferr_r;
    await_nxt    = await_r;

    if ((ferr_r == luv_pkg::VRD_NOT_LINK) || (ferr_r == luv_pkg::VRD_BAD_TYPE)) begin
    end else if (mp_r < luv_pkg::PREFIX_LEN) begin
      if (b == luv_pkg::prefix_char(mp_r[2:0])) begin
        mp_nxt = 5'(mp_r + 5'd1);
      end else begin
        ferr_nxt = luv_pkg::VRD_NOT_LINK;
      end
    end else if (mp_r < luv_pkg::HDR_DONE) begin
      if (b == luv_pkg::BAR) begin
        if (((kind_r == luv_pkg::KIND_FILE) && (ti == 4'd4)) ||
            ((kind_r == luv_pkg::KIND_SERVER) && (ti == 4'd6)) ||
            ((kind_r == luv_pkg::KIND_LIST) && (ti == 4'd10))) begin
          mp_nxt    = luv_pkg::HDR_DONE;
          fidx_nxt  = 2'd0;
          await_nxt = 1'b0;
          clr       = 1'b1;
        end else begin
          ferr_nxt = luv_pkg::VRD_BAD_TYPE;
        end
      end else if (ti == 4'd0) begin
        if (b == "f") begin
          kind_nxt = luv_pkg::KIND_FILE;
          mp_nxt   = 5'(mp_r + 5'd1);
        end else if (b == "s") begin
          kind_nxt = luv_pkg::KIND_SERVER;
          mp_nxt   = 5'(mp_r + 5'd1);
        end else begin
          ferr_nxt = luv_pkg::VRD_BAD_TYPE;
        end
      end else if ((kind_r == luv_pkg::KIND_FILE) && (ti < 4'd4) &&
                   (b == luv_pkg::file_char(ti[1:0]))) begin
        mp_nxt = 5'(mp_r + 5'd1);
      end else if ((kind_r == luv_pkg::KIND_SERVER) && (ti < 4'd6) &&
                   (b == luv_pkg::list_char(ti))) begin
        mp_nxt = 5'(mp_r + 5'd1);
      end else if ((kind_r == luv_pkg::KIND_SERVER) && (ti == 4'd6) && (b == "l")) begin
        kind_nxt = luv_pkg::KIND_LIST;
        mp_nxt   = 5'(mp_r + 5'd1);
      end else if ((kind_r == luv_pkg::KIND_LIST) && (ti < 4'd10) &&
                   (b == luv_pkg::list_char(ti))) begin
        mp_nxt = 5'(mp_r + 5'd1);
      end else begin
        ferr_nxt = luv_pkg::VRD_BAD_TYPE;
      end
    end else if ((kind_r == luv_pkg::KIND_SERVER) && (fidx_r == 2'd2)) begin
      if (await_r) begin
        await_nxt = 1'b0;
        if (b == luv_pkg::SLASH) begin
          fidx_nxt = 2'd3;
        end
      end
    end else if (fidx_r > last_field) begin
    end else if (b == luv_pkg::BAR) begin
      if (ferr_r == luv_pkg::VRD_NONE) begin
        if (fidx_r == 2'd0) begin
          if (!nonempty_r) begin
            ferr_nxt = luv_pkg::VRD_EMPTY;
          end
        end else if ((fidx_r == 2'd1) && (kind_r != luv_pkg::KIND_LIST)) begin
          if (!nonempty_r || !digits_r) begin
            ferr_nxt = luv_pkg::VRD_BAD_NUM;
          end
        end else if (fidx_r == 2'd2) begin
          if (!hexok_r || (hcnt_r != luv_pkg::HASH_LEN)) begin
            ferr_nxt = luv_pkg::VRD_BAD_HASH;
          end
        end
      end
      fidx_nxt = 2'(fidx_r + 2'd1);
      if ((kind_r == luv_pkg::KIND_SERVER) && (fidx_r == 2'd1)) begin
        await_nxt = 1'b1;
      end
      clr = 1'b1;
    end else begin
      nonempty_nxt = 1'b1;
      if (!luv_pkg::is_digit(b)) begin
        digits_nxt = 1'b0;
      end
      if (!luv_pkg::is_hex(b)) begin
        hexok_nxt = 1'b0;
      end
      if (hcnt_r < luv_pkg::HEX_SAT) begin
        hcnt_nxt = 6'(hcnt_r + 6'd1);
      end
    end

    if (clr) begin
      nonempty_nxt = 1'b0;
      digits_nxt   = 1'b1;
      hcnt_nxt     = 6'd0;
      hexok_nxt    = 1'b1;
    end

    res.link_kind = luv_pkg::KIND_NONE;
    if ((ferr_nxt == luv_pkg::VRD_NOT_LINK) || (ferr_nxt == luv_pkg::VRD_BAD_TYPE)) begin
      res.verdict = ferr_nxt;
    end else if (mp_nxt < luv_pkg::PREFIX_LEN) begin
      res.verdict = luv_pkg::VRD_NOT_LINK;
    end else if (mp_nxt < luv_pkg::HDR_DONE) begin
      res.verdict = luv_pkg::VRD_BAD_TYPE;
    end else begin
      res.link_kind = kind_nxt;
      case (kind_nxt)
        luv_pkg::KIND_FILE:   closed = (fidx_nxt == 2'd3);
        luv_pkg::KIND_SERVER: closed = (fidx_nxt == 2'd3) ||
                                       ((fidx_nxt == 2'd2) && await_nxt);
        default:              closed = (fidx_nxt >= 2'd1);
      endcase
      if (!closed) begin
        res.verdict = luv_pkg::VRD_FORMAT;
      end else if (ferr_nxt != luv_pkg::VRD_NONE) begin
        res.verdict = ferr_nxt;
      end else begin
        res.verdict = 4'(kind_nxt - 2'd1);
      end
    end

    if (item.final_byte) begin
      mp_nxt       = 5'd0;
      kind_nxt     = luv_pkg::KIND_NONE;
      fidx_nxt     = 2'd0;
      nonempty_nxt = 1'b0;
      digits_nxt   = 1'b1;
      hcnt_nxt     = 6'd0;
      hexok_nxt    = 1'b1;
      ferr_nxt     = luv_pkg::VRD_NONE;
      await_nxt    = 1'b0;
    end
  end

  assign res_valid = fire && item.final_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r       <= 5'd0;
      kind_r     <= luv_pkg::KIND_NONE;
      fidx_r     <= 2'd0;
      nonempty_r <= 1'b0;
      digits_r   <= 1'b1;
      hcnt_r     <= 6'd0;
      hexok_r    <= 1'b1;
      ferr_r     <= luv_pkg::VRD_NONE;
      await_r    <= 1'b0;
    end else if (fire) begin
      mp_r       <= mp_nxt;
      kind_r     <= kind_nxt;
      fidx_r     <= fidx_nxt;
      nonempty_r <= nonempty_nxt;
      digits_r   <= digits_nxt;
      hcnt_r     <= hcnt_nxt;
      hexok_r    <= hexok_nxt;
      ferr_r     <= ferr_nxt;
      await_r    <= await_nxt;
    end
  end

endmodule

>>> rtl/link_uri_validator.sv
// The final byte passes the input register; its verdict is then held in the output register.
// Throughput: one byte per cycle; the input register feeds the check logic directly.
// A waiting verdict in the output register stalls only the next final byte, not other bytes.
// Reset (rst_n low, synchronous) clears both valid flags and restarts the link match.
// ----------------------------------------------------------------------------
// Link URI validator
// Checks a link byte stream and gives one verdict and link kind per link.
// ----------------------------------------------------------------------------
module link_uri_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [3:0] verdict, [5:4] link_kind, [7:6] zero
);

  luv_pkg::item_t   in_item;
  luv_pkg::item_t   stg_item;
  luv_pkg::result_t res;
  luv_pkg::result_t res_r;
  logic             stg_valid;
  logic             advance;
  logic             res_valid;
  logic             out_valid_r, out_valid_nxt;

  assign in_item.text_byte  = in_tdata;
  assign in_item.final_byte = in_tlast;

  assign advance = stg_valid && (!stg_item.final_byte || !out_valid_r || out_tready);

  luv_in_stage u_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .advance   (advance),
    .stg_valid (stg_valid),
    .stg_item  (stg_item)
  );

  luv_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (stg_item),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid_nxt = res_valid ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.link_kind, res_r.verdict};

endmodule

>>> rtl/luv_checker.sv
// ----------------------------------------------------------------------------
// Link URI validator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "link_uri_validator_macros.svh"

module luv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `LUV_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid,
    "result dropped while stalled")
  `LUV_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata),
    "result changed while stalled")
  `LUV_ASSERT(a_fail_kind,
    out_tvalid && ((out_tdata[3:0] == luv_pkg::VRD_NOT_LINK) ||
    (out_tdata[3:0] == luv_pkg::VRD_BAD_TYPE)) |-> out_tdata[5:4] == luv_pkg::KIND_NONE,
    "kind set on a header failure")
  `LUV_ASSERT(a_ok_kind,
    out_tvalid && (out_tdata[3:0] < luv_pkg::VRD_NOT_LINK) |->
    out_tdata[5:4] == 2'(out_tdata[1:0] + 2'd1),
    "kind does not match success verdict")
  `LUV_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind link_uri_validator luv_checker u_luv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
